>>> rtl/core/gf2m_poly_basis_multiply_top_macros.svh
// ----------------------------------------------------------------------------
// gf2m_poly_basis_multiply_top_macros
// Assertion macros for the GF(2^M) multiplier; they use clk and rst of the
// including module.
// ----------------------------------------------------------------------------
`ifndef GF2M_POLY_BASIS_MULTIPLY_TOP_MACROS_SVH
`define GF2M_POLY_BASIS_MULTIPLY_TOP_MACROS_SVH

// same-cycle implication
`define GFPM_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("gfpm same-cycle check failed");

// next-cycle implication
`define GFPM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("gfpm next-cycle check failed");

`endif

>>> rtl/core/gfpm_pkg.sv
// ----------------------------------------------------------------------------
// gfpm_pkg
// Shared constants for the digit-serial GF(2^M) multiplier.
// ----------------------------------------------------------------------------
package gfpm_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned PORT_W  = 64;

  localparam logic [PORT_W-1:0]  MODULUS_RESET = 64'd27;
  localparam logic [DIGIT_W-1:0] DIGIT_MASK    = 4'hF;

endpackage

>>> rtl/core/gfpm_digit_step.sv
// ----------------------------------------------------------------------------
// gfpm_digit_step
// One msb-first step: acc * x^4 + a * digit, reduced modulo x^M + poly.
// ----------------------------------------------------------------------------
module gfpm_digit_step
  import gfpm_pkg::*;
#(
  parameter int unsigned FIELD_DEGREE = 64
) (
  input  logic [FIELD_DEGREE-1:0] acc,
  input  logic [FIELD_DEGREE-1:0] a,
  input  logic [DIGIT_W-1:0]      digit,
  input  logic [FIELD_DEGREE-1:0] poly,
  output logic [FIELD_DEGREE-1:0] acc_next
);

  localparam int unsigned EXT_W = FIELD_DEGREE + DIGIT_W;

  logic [EXT_W-1:0] t;
  logic [EXT_W-1:0] a_ext;
  logic [EXT_W-1:0] poly_ext;

  assign a_ext    = EXT_W'(a);
  assign poly_ext = EXT_W'(poly);

  always_comb begin
    t = {acc, {DIGIT_W{1'b0}}};
    for (int j = 0; j < DIGIT_W; j++) begin
      if (digit[j]) begin
        t = t ^ (a_ext << j);
      end
    end
    // fold the four overflow bits back, top bit first
    for (int k = EXT_W - 1; k >= FIELD_DEGREE; k--) begin
      if (t[k]) begin
        t    = t ^ (poly_ext << (k - FIELD_DEGREE));
        t[k] = 1'b0;
      end
    end
  end

  assign acc_next = t[FIELD_DEGREE-1:0];

endmodule

>>> rtl/core/gf2m_poly_basis_multiply_top.sv
// ----------------------------------------------------------------------------
// gf2m_poly_basis_multiply_top
// Digit-serial GF(2^M) multiplier in polynomial basis.
// ----------------------------------------------------------------------------
// Multiplies operand_a by operand_b modulo x^M + modulus_low, M = FIELD_DEGREE.
// Operand and modulus bits at or above M are ignored, product bits at or above
// M read zero. An item is taken when start is high and busy is low; the single
// digit step unit then consumes operand_b four bits per cycle, most significant
// digit first, and takes no new item until busy is low again. The product
// appears for exactly one cycle with done high; the receiver cannot stall it,
// so it must capture the product in that cycle. busy is low in the done cycle.
// modulus_ready is always high; write the modulus only while no multiply is
// running.
`include "gf2m_poly_basis_multiply_top_macros.svh"

module gf2m_poly_basis_multiply_top
  import gfpm_pkg::*;
#(
  parameter int unsigned FIELD_DEGREE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [PORT_W-1:0] operand_a,
  input  logic [PORT_W-1:0] operand_b,
  output logic              done,
  output logic [PORT_W-1:0] product,
  input  logic              modulus_valid,
  output logic              modulus_ready,
  input  logic [PORT_W-1:0] modulus_low
);

  localparam int unsigned M      = FIELD_DEGREE;
  localparam int unsigned DIGITS = (M + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned B_W    = DIGITS * DIGIT_W;
  localparam int unsigned CNT_W  = $clog2(DIGITS + 1);

  logic [M-1:0]       poly;
  logic [M-1:0]       a_reg;
  logic [B_W-1:0]     b_reg;
  logic [M-1:0]       acc;
  logic [CNT_W-1:0]   count;
  logic [M-1:0]       prod_reg;

  logic               accept;
  logic [B_W-1:0]     b_load;
  logic [M-1:0]       step_acc;
  logic [M-1:0]       step_a;
  logic [DIGIT_W-1:0] step_digit;
  logic [M-1:0]       acc_next;
  logic               last_step;

  assign accept        = start && !busy;
  assign modulus_ready = 1'b1;
  assign b_load        = B_W'(operand_b[M-1:0]);

  // the first digit is worked on in the accept cycle
  always_comb begin
    if (busy) begin
      step_acc   = acc;
      step_a     = a_reg;
      step_digit = b_reg[B_W-1 -: DIGIT_W] & DIGIT_MASK;
    end else begin
      step_acc   = '0;
      step_a     = operand_a[M-1:0];
      step_digit = b_load[B_W-1 -: DIGIT_W] & DIGIT_MASK;
    end
  end

  gfpm_digit_step #(
    .FIELD_DEGREE(M)
  ) u_step (
    .acc      (step_acc),
    .a        (step_a),
    .digit    (step_digit),
    .poly     (poly),
    .acc_next (acc_next)
  );

  assign last_step = busy ? (count == CNT_W'(1)) : (DIGITS == 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= M'(MODULUS_RESET);
    end else if (modulus_valid && modulus_ready) begin
      poly <= modulus_low[M-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (accept || busy) begin
        if (last_step) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy  <= 1'b1;
          count <= busy ? (count - CNT_W'(1)) : CNT_W'(DIGITS - 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_reg <= operand_a[M-1:0];
      b_reg <= b_load << DIGIT_W;
      acc   <= acc_next;
    end else if (busy) begin
      b_reg <= b_reg << DIGIT_W;
      acc   <= acc_next;
    end
    if ((accept || busy) && last_step) begin
      prod_reg <= acc_next;
    end
  end

  assign product = PORT_W'(prod_reg);

  // checks
  `GFPM_ASSERT_SAME(a_done_not_busy, done, !busy)
  `GFPM_ASSERT_NEXT(a_accept_runs, start && !busy, busy || done)
  `GFPM_ASSERT_NEXT(a_last_step_done, busy && count == CNT_W'(1), done && !busy)
  `GFPM_ASSERT_SAME(a_count_range, busy, count != '0 && count < CNT_W'(DIGITS))

endmodule
